FILE: hdl/uesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uesc_pkg
// Shared types and constants for the \uXXXX escape to UTF-8 decoder.
// ----------------------------------------------------------------------------
package uesc_pkg;

  // Number of hex digits taken into a code point
  localparam int HEX_DIGITS = 4;
  // Bytes in one escape group: backslash, 'u' and four more
  localparam int GROUP_LEN  = 6;
  // Most bytes that one input beat can produce
  localparam int PKT_MAX    = 5;

  localparam int GRP_W = $clog2(GROUP_LEN);
  localparam int CNT_W = $clog2(PKT_MAX + 1);
  localparam int IDX_W = $clog2(PKT_MAX);

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  // UTF-8 limits and marks
  localparam logic [15:0] CP_ONE_LIM = 16'h0080;
  localparam logic [15:0] CP_TWO_LIM = 16'h0800;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  TAIL_MARK  = 8'h80;
  localparam logic [7:0]  TAIL_MASK  = 8'h3F;

  // Packet of result bytes for one input beat
  typedef struct packed {
    logic [PKT_MAX-1:0][7:0] data;
    logic [CNT_W-1:0]        cnt;
    logic                    fin;
  } pkt_t;

  // Hex digit check: {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: hdl/uesc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uesc_ifs
// Valid/ready channel interfaces for escaped text in and decoded bytes out.
// ----------------------------------------------------------------------------
interface uesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface uesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

FILE: hdl/uesc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uesc_scan
// Holds the partial escape group and turns each input beat into a packet of
// result bytes in a single pass.
// ----------------------------------------------------------------------------
module uesc_scan
  import uesc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  uesc_in_if.sink       in_ch,
  input  logic          slot_free,
  output pkt_t          pkt,
  output logic          pkt_load
);

  logic [GROUP_LEN-1:0][7:0] pend_r, pend_nxt;
  logic [GRP_W-1:0]          cnt_r, cnt_nxt, held_cnt;
  logic [GRP_W-1:0]          widx;
  logic [2:0][7:0]           emit_b;
  logic [1:0]                emit_n;
  logic [7:0]                b;
  logic [4:0]                hx;
  logic [HEX_DIGITS-1:0][7:0] dig;
  logic [15:0]               cp;
  logic                      run;
  logic [4:0]                dh;
  logic [CNT_W-1:0]          total;
  logic [GRP_W-1:0]          src;

  assign b        = in_ch.in_byte;
  assign hx       = hex_decode(b);
  assign pkt_load = in_ch.valid && slot_free;
  assign in_ch.ready = slot_free;

  // Code point from the leading run of hex digits
  always_comb begin
    dig[0] = pend_r[2];
    for (int k = 1; k < HEX_DIGITS; k++) begin
      dig[k] = (k + 2 < GROUP_LEN - 1) ? pend_r[k + 2] : b;
    end
    cp  = 16'd0;
    run = 1'b1;
    dh  = 5'd0;
    for (int k = 0; k < HEX_DIGITS; k++) begin
      dh = hex_decode(dig[k]);
      if (run && dh[4]) begin
        cp = {cp[11:0], dh[3:0]};
      end else begin
        run = 1'b0;
      end
    end
  end

  // Scan step: bytes emitted and new hold state
  always_comb begin
    emit_b  = '0;
    emit_n  = 2'd0;
    held_cnt = '0;
    widx    = '0;
    case (cnt_r)
      GRP_W'(1): begin
        if (b == CHAR_U) begin
          held_cnt = GRP_W'(2);
          widx     = GRP_W'(1);
        end else if (b == CHAR_BSLASH) begin
          emit_b[0] = CHAR_BSLASH;
          emit_n    = 2'd1;
          held_cnt  = GRP_W'(1);
        end else begin
          emit_b[0] = CHAR_BSLASH;
          emit_b[1] = b;
          emit_n    = 2'd2;
        end
      end
      GRP_W'(2): begin
        if (hx[4]) begin
          held_cnt = GRP_W'(3);
          widx     = GRP_W'(2);
        end else if (b == CHAR_BSLASH) begin
          emit_b[0] = CHAR_BSLASH;
          emit_b[1] = CHAR_U;
          emit_n    = 2'd2;
          held_cnt  = GRP_W'(1);
        end else begin
          emit_b[0] = CHAR_BSLASH;
          emit_b[1] = CHAR_U;
          emit_b[2] = b;
          emit_n    = 2'd3;
        end
      end
      GRP_W'(3), GRP_W'(4): begin
        held_cnt = cnt_r + GRP_W'(1);
        widx     = cnt_r;
      end
      GRP_W'(5): begin
        // Full group: encode as UTF-8
        if (cp < CP_ONE_LIM) begin
          emit_b[0] = cp[7:0];
          emit_n    = 2'd1;
        end else if (cp < CP_TWO_LIM) begin
          emit_b[0] = LEAD_TWO | {3'd0, cp[10:6]};
          emit_b[1] = TAIL_MARK | (cp[7:0] & TAIL_MASK);
          emit_n    = 2'd2;
        end else begin
          emit_b[0] = LEAD_THREE | {4'd0, cp[15:12]};
          emit_b[1] = TAIL_MARK | ({2'd0, cp[11:6]} & TAIL_MASK);
          emit_b[2] = TAIL_MARK | (cp[7:0] & TAIL_MASK);
          emit_n    = 2'd3;
        end
      end
      default: begin
        if (b == CHAR_BSLASH) begin
          held_cnt = GRP_W'(1);
        end else begin
          emit_b[0] = b;
          emit_n    = 2'd1;
        end
      end
    endcase
  end

  // New byte lands in the hold buffer (harmless when nothing is held)
  always_comb begin
    pend_nxt       = pend_r;
    pend_nxt[widx] = b;
  end

  // Assemble packet: emitted bytes, then held bytes when the text ends
  always_comb begin
    pkt.fin = in_ch.end_of_text;
    if (in_ch.end_of_text) begin
      total   = CNT_W'(emit_n) + CNT_W'(held_cnt);
      cnt_nxt = '0;
    end else begin
      total   = CNT_W'(emit_n);
      cnt_nxt = held_cnt;
    end
    pkt.cnt = total;
    src     = '0;
    for (int i = 0; i < PKT_MAX; i++) begin
      src = GRP_W'(i) - GRP_W'(emit_n);
      if (i < 3 && 2'(i) < emit_n) begin
        pkt.data[i] = emit_b[i];
      end else begin
        pkt.data[i] = pend_nxt[src];
      end
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (pkt_load) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_load) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: hdl/uesc_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uesc_emit
// Result register: holds one packet, hands out one beat a cycle when ready.
// ----------------------------------------------------------------------------
module uesc_emit
  import uesc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  pkt_t          pkt,
  input  logic          pkt_load,
  output logic          slot_free,
  uesc_out_if.source    out_ch
);

  logic [PKT_MAX-1:0][7:0] data_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    fin_r;
  logic                    vld_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    last;
  logic                    take;

  assign last = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign take = vld_r && out_ch.ready;

  // Free when empty or when the final beat leaves this cycle
  assign slot_free = !vld_r || (take && last);

  assign out_ch.valid     = vld_r;
  assign out_ch.out_byte  = data_r[idx_r];
  assign out_ch.run_last  = last;
  assign out_ch.text_done = last && fin_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (pkt_load) begin
      // an input that only joins the hold buffer gives no result
      vld_r <= (pkt.cnt != '0);
      idx_r <= '0;
    end else if (take && last) begin
      vld_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pkt_load) begin
      data_r <= pkt.data;
      cnt_r  <= pkt.cnt;
      fin_r  <= pkt.fin;
    end
  end

endmodule

FILE: hdl/unicode_escape_to_utf8_core.sv
`timescale 1ns / 1ps
// Timing: the first result beat appears in the cycle after its input is taken.
// Throughput: an input beat yields 0 to 5 result beats, one per cycle unless
// stalled (none while an escape is still being gathered, 3 at most otherwise,
// 5 for a flush at end of text); a new input is taken when the slot is empty
// or as its last beat leaves, so beats with no result can follow every cycle.
// Reset: synchronous active-low rst_n empties the hold buffer and result slot.
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8_core
// Streaming decoder of \uXXXX escapes into UTF-8; other bytes pass through.
// ----------------------------------------------------------------------------
module unicode_escape_to_utf8_core
  import uesc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  uesc_in_if.sink    in_ch,
  uesc_out_if.source out_ch
);

  pkt_t pkt;
  logic pkt_load;
  logic slot_free;

  // Scanner and hold buffer
  uesc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slot_free (slot_free),
    .pkt       (pkt),
    .pkt_load  (pkt_load)
  );

  // Result serialiser
  uesc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt       (pkt),
    .pkt_load  (pkt_load),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule
